// ----- design/lfsr113_pkg.sv -----
package lfsr113_pkg;

    // Request codes carried in the mode field of an input item.
    typedef enum logic [1:0] {
        MODE_SEED   = 2'd0,
        MODE_DRAW   = 2'd1,
        MODE_POISON = 2'd2
    } t_mode;

    // Result codes carried in the kind field of an output item.
    typedef enum logic [1:0] {
        KIND_RANDOM = 2'd0,
        KIND_HEAP   = 2'd1,
        KIND_STACK  = 2'd2
    } t_kind;

    localparam logic [31:0] SEED_MIN   = 32'd128;
    localparam logic [7:0]  POISON_TAG = 8'hF3;

    // Component masks of the four Tausworthe recurrences.
    localparam logic [31:0] MASK_ONE   = 32'hFFFF_FFFE;
    localparam logic [31:0] MASK_TWO   = 32'hFFFF_FFF8;
    localparam logic [31:0] MASK_THREE = 32'hFFFF_FFF0;
    localparam logic [31:0] MASK_FOUR  = 32'hFFFF_FF80;

    // Result queue geometry.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seed;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  kind;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] one;
        logic [31:0] two;
        logic [31:0] three;
        logic [31:0] four;
    } t_comps;

    // One step of all four components together.
    function automatic t_comps lfsr_step(input t_comps c);
        t_comps      n;
        logic [31:0] t;
        t       = ((c.one << 6) ^ c.one) >> 13;
        n.one   = ((c.one & MASK_ONE) << 18) ^ t;
        t       = ((c.two << 2) ^ c.two) >> 27;
        n.two   = ((c.two & MASK_TWO) << 2) ^ t;
        t       = ((c.three << 13) ^ c.three) >> 21;
        n.three = ((c.three & MASK_THREE) << 7) ^ t;
        t       = ((c.four << 3) ^ c.four) >> 12;
        n.four  = ((c.four & MASK_FOUR) << 13) ^ t;
        return n;
    endfunction

    // The number returned by a draw is the XOR of the new components.
    function automatic logic [31:0] comp_xor(input t_comps c);
        return c.one ^ c.two ^ c.three ^ c.four;
    endfunction

    // Poison word: tag byte, low byte of first draw, low half of second draw.
    function automatic logic [31:0] poison_word(input logic [31:0] first_draw,
                                                input logic [31:0] second_draw);
        return {POISON_TAG, first_draw[7:0], second_draw[15:0]};
    endfunction

endpackage

// ----- design/lfsr113_random_with_poison.sv -----
// LFSR113 combined Tausworthe generator with poison words. Mode 0 reseeds all
// four components (seeds below 128 have 128 added) and gives no result, mode 1
// gives one random number, mode 2 gives a heap poison word then a stack poison
// word, and mode 3 is ignored. Reset behaves as a reseed with 0. The block
// accepts one item per cycle while o_in_stall is low: all four chained steps of the
// generator are worked out in one pass from the component registers, and results
// are registered into the queue on acceptance. Results leave through a four-entry
// queue at one per cycle while i_out_stall is low, so a stream of poison requests,
// each giving two results, is limited by the output side; o_in_stall rises whenever
// fewer than two queue entries are free.
module lfsr113_random_with_poison (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  lfsr113_pkg::t_in_item  i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output lfsr113_pkg::t_out_item o_out
);
    import lfsr113_pkg::*;

    t_comps                r_comps;
    t_comps                n_comps;
    t_out_item             r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic [QUEUE_AW:0]     n_count;

    t_comps                draw_one;
    t_comps                draw_two;
    t_comps                draw_three;
    t_comps                draw_four;
    logic [31:0]           seed_value;
    logic                  in_accept;
    logic                  out_pop;
    logic [1:0]            push_cnt;
    t_out_item             push_first;
    t_out_item             push_second;

    // Handshake: stall only on queue space, which depends on registers alone.
    assign o_in_stall  = (r_count > (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_pop     = o_out_valid && !i_out_stall;
    assign o_out       = r_queue[r_rd_ptr];

    // Four successive draws from the current state.
    assign draw_one   = lfsr_step(r_comps);
    assign draw_two   = lfsr_step(draw_one);
    assign draw_three = lfsr_step(draw_two);
    assign draw_four  = lfsr_step(draw_three);
    assign seed_value = (i_in.seed < SEED_MIN) ? (i_in.seed + SEED_MIN) : i_in.seed;

    // Decode the request into the new state and up to two results.
    always_comb begin
        n_comps     = r_comps;
        push_cnt    = 2'd0;
        push_first  = '0;
        push_second = '0;
        if (in_accept) begin
            case (i_in.mode)
                MODE_SEED: begin
                    n_comps = '{one: seed_value, two: seed_value,
                                three: seed_value, four: seed_value};
                end
                MODE_DRAW: begin
                    n_comps    = draw_one;
                    push_cnt   = 2'd1;
                    push_first = '{value: comp_xor(draw_one), kind: KIND_RANDOM,
                                   last: 1'b1};
                end
                MODE_POISON: begin
                    n_comps     = draw_four;
                    push_cnt    = 2'd2;
                    push_first  = '{value: poison_word(comp_xor(draw_one),
                                                       comp_xor(draw_two)),
                                    kind: KIND_HEAP, last: 1'b0};
                    push_second = '{value: poison_word(comp_xor(draw_three),
                                                       comp_xor(draw_four)),
                                    kind: KIND_STACK, last: 1'b1};
                end
                default: begin
                    n_comps = r_comps;
                end
            endcase
        end
    end

    assign n_count = r_count + (QUEUE_AW+1)'(push_cnt) - (QUEUE_AW+1)'(out_pop);

    // Component state and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comps  <= '{one: SEED_MIN, two: SEED_MIN, three: SEED_MIN, four: SEED_MIN};
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_comps  <= n_comps;
            r_wr_ptr <= r_wr_ptr + QUEUE_AW'(push_cnt);
            r_rd_ptr <= r_rd_ptr + QUEUE_AW'(out_pop);
            r_count  <= n_count;
        end
    end

    // Result queue storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= push_first;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + QUEUE_AW'(1)] <= push_second;
        end
    end

    // The queue never overfills.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A poison request adds exactly two entries to the queue.
    a_poison_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.mode == MODE_POISON) |=>
        r_count == $past(r_count) + (QUEUE_AW+1)'(2) - (QUEUE_AW+1)'($past(out_pop)))
        else $error("poison request did not queue two items");

    // A reseed leaves all four components equal and at least the minimum.
    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.mode == MODE_SEED) |=>
        (r_comps.one == r_comps.two) && (r_comps.one == r_comps.four) &&
        (r_comps.one == r_comps.three) && (r_comps.one >= SEED_MIN))
        else $error("reseed did not load every component");

    // Poison items carry the tag byte and only the stack word closes a pair.
    a_poison_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == KIND_HEAP || o_out.kind == KIND_STACK)) |->
        (o_out.value[31:24] == POISON_TAG) && (o_out.last == (o_out.kind == KIND_STACK)))
        else $error("malformed poison item");

    // A random number is always the last item of its request.
    a_random_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_RANDOM) |-> o_out.last)
        else $error("random item without last");

endmodule

// ----- sim/lfsr113_stream_monitor.sv -----
module lfsr113_stream_monitor (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  lfsr113_pkg::t_in_item  i_in,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  lfsr113_pkg::t_out_item i_out,
    output int                     o_fail_count,
    output int                     o_pending
);
    import lfsr113_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Private copy of the four generator components.
    logic [31:0] taus_a;
    logic [31:0] taus_b;
    logic [31:0] taus_c;
    logic [31:0] taus_d;

    // Words the block still owes, oldest first.
    t_out_item due_words[$];
    int        fail_count = 0;

    // A reseed loads every component, lifting small seeds clear of the minimum.
    function automatic void reseed_generator(input logic [31:0] seed);
        logic [31:0] start;
        start = seed;
        if (start < SEED_MIN) begin
            start = start + SEED_MIN;
        end
        taus_a = start;
        taus_b = start;
        taus_c = start;
        taus_d = start;
    endfunction

    // Advance all four recurrences once and return the combined number.
    function automatic logic [31:0] draw_number();
        logic [31:0] fb;
        fb     = ((taus_a << 6) ^ taus_a) >> 13;
        taus_a = ((taus_a & 32'hFFFF_FFFE) << 18) ^ fb;
        fb     = ((taus_b << 2) ^ taus_b) >> 27;
        taus_b = ((taus_b & 32'hFFFF_FFF8) << 2) ^ fb;
        fb     = ((taus_c << 13) ^ taus_c) >> 21;
        taus_c = ((taus_c & 32'hFFFF_FFF0) << 7) ^ fb;
        fb     = ((taus_d << 3) ^ taus_d) >> 12;
        taus_d = ((taus_d & 32'hFFFF_FF80) << 13) ^ fb;
        return taus_a ^ taus_b ^ taus_c ^ taus_d;
    endfunction

    // A poison word takes two draws in order: the byte first, then the half.
    function automatic logic [31:0] poison_from_draws();
        logic [31:0] first_draw;
        logic [31:0] second_draw;
        first_draw  = draw_number();
        second_draw = draw_number();
        return {POISON_TAG, first_draw[7:0], second_draw[15:0]};
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item   want;
        logic [31:0] heap_word;
        logic [31:0] stack_word;
        if (!i_rst_n) begin
            reseed_generator(32'd0);
            due_words.delete();
        end else begin
            // Results are checked first; none can belong to an item taken at this edge.
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result: value %h kind %0d last %0d",
                                 i_out.value, i_out.kind, i_out.last);
                    end
                end else begin
                    want = due_words.pop_front();
                    if (i_out.value !== want.value || i_out.kind !== want.kind ||
                        i_out.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("mismatch: expected value %h kind %0d last %0d,",
                                     want.value, want.kind, want.last,
                                     " got value %h kind %0d last %0d",
                                     i_out.value, i_out.kind, i_out.last);
                        end
                    end
                end
            end

            // Work out what each accepted item must produce.
            if (i_in_valid && !i_in_stall) begin
                case (i_in.mode)
                    MODE_SEED: begin
                        reseed_generator(i_in.seed);
                    end
                    MODE_DRAW: begin
                        due_words.push_back(t_out_item'{value: draw_number(),
                                                        kind: KIND_RANDOM, last: 1'b1});
                    end
                    MODE_POISON: begin
                        heap_word  = poison_from_draws();
                        stack_word = poison_from_draws();
                        due_words.push_back(t_out_item'{value: heap_word,
                                                        kind: KIND_HEAP, last: 1'b0});
                        due_words.push_back(t_out_item'{value: stack_word,
                                                        kind: KIND_STACK, last: 1'b1});
                    end
                    default: begin
                        // The unused code leaves the generator untouched.
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_words.size();
    end

endmodule

// ----- sim/tb_lfsr113_random_with_poison.sv -----
module tb_lfsr113_random_with_poison;
    import lfsr113_pkg::*;

    localparam int         RANDOM_ITEMS   = 1050;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         DRAIN_CYCLES   = 16;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending_count;
    int        idle_cycles = 0;
    int        in_calm_left = 0;

    lfsr113_random_with_poison dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    lfsr113_stream_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Clock with a period of eight units.
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Offer one item after a random pause and hold it until it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [31:0] seed);
        int gap;
        if (in_calm_left > 0) begin
            gap = 0;
            in_calm_left--;
        end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0) begin
                in_calm_left = $urandom_range(16, 48);
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{mode: mode, seed: seed};
        do @(posedge clk); while (in_stall);
    endtask

    // Stimulus: reset, a directed opening, then a long random stream.
    initial begin : stimulus
        int          taken;
        int          pick;
        logic [31:0] seed;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Draws straight from the reset state, then the seed boundaries.
        send_request(MODE_DRAW, 32'd0);
        send_request(MODE_POISON, 32'hFFFF_FFFF);
        send_request(MODE_SEED, 32'd0);
        send_request(MODE_DRAW, 32'd0);
        send_request(MODE_SEED, 32'd127);
        send_request(MODE_DRAW, 32'd0);
        send_request(MODE_SEED, 32'd128);
        send_request(MODE_POISON, 32'd0);
        send_request(MODE_SEED, 32'hFFFF_FFFF);
        send_request(MODE_DRAW, 32'hFFFF_FFFF);
        send_request(MODE_POISON, 32'd0);
        send_request(MODE_SEED, 32'h8000_0000);
        send_request(MODE_DRAW, 32'd0);
        // The unused code must neither answer nor disturb the generator.
        send_request(MODE_UNUSED, 32'hFFFF_FFFF);
        send_request(MODE_DRAW, 32'd0);
        send_request(MODE_SEED, 32'd1);
        send_request(MODE_POISON, 32'd0);
        send_request(MODE_POISON, 32'd0);
        send_request(MODE_DRAW, 32'd0);
        send_request(MODE_UNUSED, 32'd0);
        send_request(MODE_SEED, 32'h7FFF_FFFF);
        send_request(MODE_POISON, 32'd0);

        // Mostly draws and poison pairs, with occasional reseeds and unused codes.
        taken = 0;
        while (taken < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_request(MODE_DRAW, $urandom);
                taken++;
            end else if (pick < 85) begin
                send_request(MODE_POISON, $urandom);
                taken++;
            end else if (pick < 95) begin
                case ($urandom_range(0, 2))
                    0:       seed = $urandom;
                    1:       seed = $urandom_range(0, 255);
                    default: seed = $urandom_range(120, 135);
                endcase
                send_request(MODE_SEED, seed);
                taken++;
            end else begin
                send_request(MODE_UNUSED, $urandom);
            end
        end
        in_valid <= 1'b0;

        // Let every owed word arrive, then give stray results a chance to show.
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: random stall before each result, with calm stretches now and then.
    initial begin : receiver
        int hold;
        int calm_left;
        calm_left = 0;
        forever begin
            if (calm_left > 0) begin
                hold = 0;
                calm_left--;
            end else begin
                hold = $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0) begin
                    calm_left = $urandom_range(16, 48);
                end
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- lfsr113_random_with_poison.f -----
design/lfsr113_pkg.sv
design/lfsr113_random_with_poison.sv
sim/lfsr113_stream_monitor.sv
sim/tb_lfsr113_random_with_poison.sv
